[rtl/error_diffusion_dither_defines.svh]
// -----------------------------------------------------------------------------
// Error diffusion dither - assertion macros
// Shared property forms for the checker; clock and reset come from the scope.
// -----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define EDD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define EDD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/edd_pkg.sv]
// -----------------------------------------------------------------------------
// Error diffusion dither - package
// Sizes, codes, types and address helpers shared by the block and its checker.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int BANK_DEPTH = MAX_WIDTH + 1;
   localparam int COL_W      = $clog2(BANK_DEPTH);
   localparam int LB_DEPTH   = 2 * BANK_DEPTH;
   localparam int LB_AW      = $clog2(LB_DEPTH);
   localparam int MAP_DEPTH  = 32768;
   localparam int PAL_DEPTH  = 256;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   // beat kinds carried on tuser
   localparam logic [1:0] MODE_PIXEL = 2'd0;
   localparam logic [1:0] MODE_MAP   = 2'd1;
   localparam logic [1:0] MODE_DPAL  = 2'd2;
   localparam logic [1:0] MODE_SPAL  = 2'd3;

   // source pixel formats
   localparam logic [1:0] FMT_RGB24   = 2'd0;
   localparam logic [1:0] FMT_RGB16   = 2'd1;
   localparam logic [1:0] FMT_INDEXED = 2'd2;

   // three 8-bit lanes, red in lane 0
   typedef logic [2:0][7:0] rgb_type;

   // bank 0 occupies the lower half of the line buffer
   function automatic logic [LB_AW-1:0] lb_addr(input logic bank,
                                                 input logic [COL_W-1:0] col);
      if (bank)
         return LB_AW'(BANK_DEPTH) + LB_AW'(col);
      return LB_AW'(col);
   endfunction

endpackage

`default_nettype wire

[rtl/edd_ram.sv]
// -----------------------------------------------------------------------------
// Error diffusion dither - simple dual-port RAM
// One write and one registered read per cycle; a read of the address being
// written returns the new data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/error_diffusion_dither.sv]
// -----------------------------------------------------------------------------
// Error diffusion dither - top level
// Floyd-Steinberg style dither of RGB, 16-bit or indexed pixels to plane codes.
// -----------------------------------------------------------------------------
// Use:
//   req_* carries one beat per item; req_tuser selects a pixel or a write to
//   the colour map, destination palette or source palette. A pixel yields one
//   beat on rsp_*; table writes yield none. csr_we/csr_wdata set the source
//   format; the user must write it only while idle; it is not enforced.
// Pipeline:
//   A pixel moves through s1, s2 and s3 to the output register; a new pixel
//   waits until the one before is leaving s3: the right-hand error runs from
//   the error sum through the colour map and destination palette reads back
//   to the next sum. Table writes are taken every cycle the input is ready.
// Reset:
//   Synchronous. After reset the line buffer (two banks of MAX_WIDTH+1
//   entries) is swept to zero, entry by entry, with req_tready low.
// Stall:
//   A result waits in the output register while the next pixel proceeds to
//   its last stage and holds there; req_tready then stays low.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither
   import edd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // pixel_value[23:0], map_key[38:24], entry_index[46:39], entry_red[54:47],
   // entry_green[62:55], entry_blue[70:63], entry_code[78:71], zero[79]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // out_code[7:0], out_index[15:8]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   // input fields
   logic [23:0] in_pv;
   logic [14:0] in_key;
   logic [7:0]  in_idx;
   logic [7:0]  in_code;
   rgb_type     in_rgb;

   assign in_pv     = req_tdata[23:0];
   assign in_key    = req_tdata[38:24];
   assign in_idx    = req_tdata[46:39];
   assign in_rgb[0] = req_tdata[54:47];
   assign in_rgb[1] = req_tdata[62:55];
   assign in_rgb[2] = req_tdata[70:63];
   assign in_code   = req_tdata[78:71];

   // control state
   logic              clear_ff, clear_in;
   logic [LB_AW-1:0]  clr_addr_ff, clr_addr_in;
   logic [1:0]        format_ff;
   logic [COL_W-1:0]  column_ff, column_in;
   logic              bank_ff, bank_in;
   logic              v1_ff, v2_ff, v3_ff;
   logic              out_valid_ff, out_valid_in;
   rgb_type           right_err_ff, right_err_in;

   // stage payload
   logic [23:0]       s1_pv_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff;
   logic [COL_W-1:0]  s1_col_ff, s2_col_ff, s3_col_ff;
   logic              s1_wb_ff, s2_wb_ff, s3_wb_ff;
   rgb_type           s2_ch_ff, s3_ch_ff;
   logic [7:0]        s3_idx_ff;
   logic [7:0]        out_code_ff, out_index_ff;
   logic              out_last_ff;

   logic accept, pix_acc, c3_done;

   // memory ports
   logic [7:0]        cmap_rd;
   logic [31:0]       dpal_rd;
   rgb_type           spal_rd;
   rgb_type           below_rd, bleft_rd;
   logic              lb_we;
   logic [LB_AW-1:0]  lb_waddr;
   rgb_type           lb_below_wd, lb_bleft_wd;

   // datapath
   rgb_type           src;
   rgb_type           clamped;
   logic [2:0][10:0]  sum;
   logic [14:0]       key_c1;
   rgb_type           pal_rgb;
   logic [2:0][9:0]   diff;
   logic [2:0][12:0]  dext, m7, m5, m3;
   rgb_type           e7, e5, e3;

   assign c3_done    = v3_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_ff && !v1_ff && !v2_ff && (!v3_ff || c3_done);
   assign accept     = req_tvalid && req_tready;
   assign pix_acc    = accept && (req_tuser == MODE_PIXEL);

   // ---------------------------------------------------------------- memories
   edd_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_cmap (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == MODE_MAP)),
      .wr_addr (in_key),
      .wr_data (in_idx),
      .rd_en   (v1_ff),
      .rd_addr (key_c1),
      .rd_data (cmap_rd)
   );

   edd_ram #(.WIDTH(32), .DEPTH(PAL_DEPTH)) u_dpal (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == MODE_DPAL)),
      .wr_addr (in_idx),
      .wr_data ({in_code, in_rgb}),
      .rd_en   (v2_ff),
      .rd_addr (cmap_rd),
      .rd_data (dpal_rd)
   );

   edd_ram #(.WIDTH(24), .DEPTH(PAL_DEPTH)) u_spal (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == MODE_SPAL)),
      .wr_addr (in_idx),
      .wr_data (in_rgb),
      .rd_en   (pix_acc),
      .rd_addr (in_pv[7:0]),
      .rd_data (spal_rd)
   );

   // write port: clearing sweep, finished pixel at its column, or the zeroing
   // of the next column while a pixel sits in its first stage
   always_comb begin
      lb_we       = 1'b0;
      lb_waddr    = lb_addr(s1_wb_ff, s1_col_ff + COL_W'(1));
      lb_below_wd = '0;
      lb_bleft_wd = '0;
      if (clear_ff) begin
         lb_we    = 1'b1;
         lb_waddr = clr_addr_ff;
      end else if (c3_done) begin
         lb_we       = 1'b1;
         lb_waddr    = lb_addr(s3_wb_ff, s3_col_ff);
         lb_below_wd = e5;
         lb_bleft_wd = e3;
      end else if (v1_ff) begin
         lb_we = 1'b1;
      end
   end

   edd_ram #(.WIDTH(24), .DEPTH(LB_DEPTH)) u_lb_below (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (lb_waddr),
      .wr_data (lb_below_wd),
      .rd_en   (pix_acc),
      .rd_addr (lb_addr(!bank_ff, column_ff)),
      .rd_data (below_rd)
   );

   edd_ram #(.WIDTH(24), .DEPTH(LB_DEPTH)) u_lb_bleft (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (lb_waddr),
      .wr_data (lb_bleft_wd),
      .rd_en   (pix_acc),
      .rd_addr (lb_addr(!bank_ff, column_ff + COL_W'(1))),
      .rd_data (bleft_rd)
   );

   // ---------------------------------------------------------- stage 1: sum
   always_comb begin
      unique case (format_ff)
         FMT_RGB16: begin
            src[0] = {s1_pv_ff[15:11], 3'b000};
            src[1] = {s1_pv_ff[10:6], 3'b000};
            src[2] = {s1_pv_ff[4:0], 3'b000};
         end
         FMT_INDEXED: begin
            src = spal_rd;
         end
         default: begin
            src[0] = s1_pv_ff[23:16];
            src[1] = s1_pv_ff[15:8];
            src[2] = s1_pv_ff[7:0];
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         sum[k] = {3'b000, src[k]}
                + {{3{right_err_ff[k][7]}}, right_err_ff[k]}
                + {{3{below_rd[k][7]}}, below_rd[k]}
                + {{3{bleft_rd[k][7]}}, bleft_rd[k]};
         if (sum[k][10]) begin
            clamped[k] = 8'd0;
         end else if (sum[k][9:8] != 2'b00) begin
            clamped[k] = 8'd255;
         end else begin
            clamped[k] = sum[k][7:0];
         end
      end
      key_c1 = {clamped[0][7:3], clamped[1][7:3], clamped[2][7:3]};
   end

   // ------------------------------------------------------- stage 3: errors
   assign pal_rgb = dpal_rd[23:0];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = {2'b00, s3_ch_ff[k]} - {2'b00, pal_rgb[k]};
         dext[k] = {{3{diff[k][9]}}, diff[k]};
         m7[k]   = (dext[k] << 3) - dext[k];
         m5[k]   = (dext[k] << 2) + dext[k];
         m3[k]   = (dext[k] << 1) + dext[k];
         // floor of a sixteenth: drop four bits of the two's complement word
         e7[k]   = m7[k][11:4];
         e5[k]   = m5[k][11:4];
         e3[k]   = m3[k][11:4];
      end
   end

   // ---------------------------------------------------------- next state
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         if (clr_addr_ff == LB_AW'(LB_DEPTH - 1)) begin
            clear_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + LB_AW'(1);
         end
      end

      column_in = column_ff;
      bank_in   = bank_ff;
      if (pix_acc) begin
         if (req_tlast) begin
            column_in = '0;
            bank_in   = !bank_ff;
         end else if (column_ff != COL_W'(MAX_WIDTH - 1)) begin
            column_in = column_ff + COL_W'(1);
         end
      end

      right_err_in = right_err_ff;
      if (c3_done) begin
         right_err_in = s3_last_ff ? '0 : e7;
      end

      out_valid_in = out_valid_ff;
      if (c3_done) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         format_ff    <= FMT_RGB24;
         column_ff    <= '0;
         bank_ff      <= 1'b0;
         right_err_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         if (csr_we) begin
            format_ff <= csr_wdata;
         end
         column_ff    <= column_in;
         bank_ff      <= bank_in;
         right_err_ff <= right_err_in;
         v1_ff        <= pix_acc;
         v2_ff        <= v1_ff;
         // hold the last stage until the output register can take it
         v3_ff        <= v2_ff || (v3_ff && !c3_done);
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_pv_ff   <= in_pv;
         s1_last_ff <= req_tlast;
         s1_col_ff  <= column_ff;
         s1_wb_ff   <= bank_ff;
      end
      if (v1_ff) begin
         s2_ch_ff   <= clamped;
         s2_last_ff <= s1_last_ff;
         s2_col_ff  <= s1_col_ff;
         s2_wb_ff   <= s1_wb_ff;
      end
      if (v2_ff) begin
         s3_ch_ff   <= s2_ch_ff;
         s3_idx_ff  <= cmap_rd;
         s3_last_ff <= s2_last_ff;
         s3_col_ff  <= s2_col_ff;
         s3_wb_ff   <= s2_wb_ff;
      end
      if (c3_done) begin
         out_code_ff  <= dpal_rd[31:24];
         out_index_ff <= s3_idx_ff;
         out_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_index_ff, out_code_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

[rtl/edd_checker.sv]
// -----------------------------------------------------------------------------
// Error diffusion dither - port checker
// Watches the top-level ports for pacing and output hold over time.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "error_diffusion_dither_defines.svh"

module edd_checker
   import edd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [1:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   logic                rsp_stall, pixel_beat;
   logic [RSP_DATA_W:0] rsp_beat;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign pixel_beat = req_tvalid && req_tready && (req_tuser == MODE_PIXEL);
   assign rsp_beat   = {rsp_tlast, rsp_tdata};

   // a stalled result beat holds its payload
   `EDD_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_beat), "stalled beat changed")

   // req_tready stays low while an accepted pixel is in its first and second stages
   `EDD_ASSERT_NXT(a_pixel_pace, pixel_beat, !req_tready ##1 !req_tready, "pixel taken too soon")

   // the line buffer sweep keeps the input closed as reset drops
   `EDD_ASSERT_IMP(a_clear_closed, $fell(reset), !req_tready, "input open during sweep")

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (.*);

`default_nettype wire

[dv/error_diffusion_dither_test.sv]
// -----------------------------------------------------------------------------
// Error diffusion dither - block-level test
// Loads the colour map and both palettes, then streams lines of pixels in
// every source format, with random gaps on both sides. Each result beat is
// checked against a behavioural dither of the same pixel.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module error_diffusion_dither_test;
   import edd_pkg::*;

   localparam int         IDLE_LIMIT = 10000;
   localparam logic [1:0] FMT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [23:0] pixel_value;
      logic        last;
      logic [14:0] map_key;
      logic [7:0]  entry_index;
      logic [7:0]  entry_red;
      logic [7:0]  entry_green;
      logic [7:0]  entry_blue;
      logic [7:0]  entry_code;
   } host_item_type;

   typedef struct packed {
      logic [7:0] code;
      logic [7:0] pal_index;
      logic       line_done;
   } dither_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [1:0]            csr_wdata  = FMT_RGB24;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = MODE_PIXEL;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // behavioural copy of the block state
   logic [7:0] colour_map [MAP_DEPTH];
   rgb_type    dest_rgb [PAL_DEPTH];
   logic [7:0] dest_code [PAL_DEPTH];
   rgb_type    src_rgb [PAL_DEPTH];
   byte        below_err [2][BANK_DEPTH][3];
   byte        below_left_err [2][BANK_DEPTH][3];
   int         right_err [3];
   int         line_column;
   bit         write_bank;
   logic [1:0] pixel_fmt = FMT_RGB24;

   host_item_type     host_beats [$];
   dither_result_type due_results [$];
   host_item_type     held_item;
   int                send_gap, recv_gap, calm_left, idle_cycles, mismatches;
   bit                calm;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   error_diffusion_dither dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic host_item_type pixel_item(input logic [23:0] value, input logic last);
      host_item_type it;
      it.mode        = MODE_PIXEL;
      it.pixel_value = value;
      it.last        = last;
      it.map_key     = 15'($urandom);
      it.entry_index = 8'($urandom);
      it.entry_red   = 8'($urandom);
      it.entry_green = 8'($urandom);
      it.entry_blue  = 8'($urandom);
      it.entry_code  = 8'($urandom);
      return it;
   endfunction

   function automatic host_item_type table_item(input logic [1:0] mode, input logic [14:0] key,
                                                input logic [7:0] slot, input logic [7:0] red,
                                                input logic [7:0] green, input logic [7:0] blue,
                                                input logic [7:0] code);
      host_item_type it;
      it.mode        = mode;
      it.pixel_value = 24'($urandom);
      it.last        = 1'($urandom);
      it.map_key     = key;
      it.entry_index = slot;
      it.entry_red   = red;
      it.entry_green = green;
      it.entry_blue  = blue;
      it.entry_code  = code;
      return it;
   endfunction

   function automatic void load_table(input host_item_type it);
      case (it.mode)
         MODE_MAP: colour_map[it.map_key] = it.entry_index;
         MODE_DPAL: begin
            dest_rgb[it.entry_index]  = {it.entry_blue, it.entry_green, it.entry_red};
            dest_code[it.entry_index] = it.entry_code;
         end
         MODE_SPAL: src_rgb[it.entry_index] = {it.entry_blue, it.entry_green, it.entry_red};
         default: ;
      endcase
   endfunction

   function automatic dither_result_type dither_pixel(input host_item_type it);
      rgb_type           src;
      int                level [3];
      int                k, col, wr, rd, sum, diff;
      logic [14:0]       key;
      logic [7:0]        pick;
      dither_result_type res;
      case (pixel_fmt)
         FMT_RGB16: begin
            src[0] = {it.pixel_value[15:11], 3'b000};
            src[1] = {it.pixel_value[10:6], 3'b000};
            src[2] = {it.pixel_value[4:0], 3'b000};
         end
         FMT_INDEXED: src = src_rgb[it.pixel_value[7:0]];
         default: src = {it.pixel_value[7:0], it.pixel_value[15:8], it.pixel_value[23:16]};
      endcase
      col = (line_column > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : line_column;
      wr  = int'(write_bank);
      rd  = int'(!write_bank);
      for (k = 0; k < 3; k++) begin
         sum = int'(src[k]) + right_err[k] + below_err[rd][col][k]
             + below_left_err[rd][col + 1][k];
         level[k] = (sum < 0) ? 0 : (sum > 255) ? 255 : sum;
      end
      key  = {level[0][7:3], level[1][7:3], level[2][7:3]};
      pick = colour_map[key];
      for (k = 0; k < 3; k++) begin
         diff = level[k] - int'(dest_rgb[pick][k]);
         // arithmetic shift gives the floored sixteenths
         right_err[k]                = (7 * diff) >>> 4;
         below_err[wr][col][k]       = byte'((5 * diff) >>> 4);
         below_left_err[wr][col][k]  = byte'((3 * diff) >>> 4);
         below_err[wr][col + 1][k]      = 0;
         below_left_err[wr][col + 1][k] = 0;
      end
      if (it.last) begin
         write_bank  = !write_bank;
         line_column = 0;
         for (k = 0; k < 3; k++)
            right_err[k] = 0;
      end else begin
         line_column = (col + 1 > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : col + 1;
      end
      res.code      = dest_code[pick];
      res.pal_index = pick;
      res.line_done = it.last;
      return res;
   endfunction

   // stretches of calm with no gaps on either side
   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm_left <= $urandom_range(40, 400);
         calm      <= ($urandom_range(0, 3) == 0);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (held_item.mode == MODE_PIXEL)
               due_results.push_back(dither_pixel(held_item));
            else
               load_table(held_item);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (host_beats.size() != 0) begin
               held_item = host_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, held_item.entry_code, held_item.entry_blue,
                              held_item.entry_green, held_item.entry_red,
                              held_item.entry_index, held_item.map_key,
                              held_item.pixel_value};
               req_tuser  <= held_item.mode;
               req_tlast  <= held_item.last;
               send_gap   <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      dither_result_type want;
      int                next_gap;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result beat: out_code %0d, out_index %0d, line_done %0d",
                      rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[7:0] !== want.code) begin
                  $error("out_code: expected %0d, got %0d", want.code, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[15:8] !== want.pal_index) begin
                  $error("out_index: expected %0d, got %0d", want.pal_index, rsp_tdata[15:8]);
                  mismatches++;
               end
               if (rsp_tlast !== want.line_done) begin
                  $error("line_done: expected %0d, got %0d", want.line_done, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            next_gap = pick_gap();
            recv_gap   <= next_gap;
            rsp_tready <= (next_gap == 0);
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 7) != 0);
         end
      end
   end

   // watchdog: allows for the line buffer sweep after reset
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic wait_idle();
      do
         @(negedge clock);
      while (host_beats.size() != 0 || req_tvalid || due_results.size() != 0);
   endtask

   task automatic set_format(input logic [1:0] fmt);
      wait_idle();
      // table writes leave no result: give the last one time to land
      repeat (6) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= fmt;
      pixel_fmt  = fmt;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_lines(input int pixels);
      int width, run, roll;
      width = 4;
      while (pixels > 0) begin
         roll = $urandom_range(0, 99);
         // otherwise keep the width, so the line matches the one above
         if (roll < 65)
            width = $urandom_range(1, 8);
         else if (roll < 85)
            width = $urandom_range(9, 40);
         for (run = 0; run < width; run++) begin
            if ($urandom_range(0, 11) == 0)
               host_beats.push_back(table_item(2'($urandom_range(MODE_MAP, MODE_SPAL)),
                                               15'($urandom), 8'($urandom), 8'($urandom),
                                               8'($urandom), 8'($urandom), 8'($urandom)));
            host_beats.push_back(pixel_item(24'($urandom), run == width - 1));
         end
         pixels -= width;
      end
   endtask

   initial begin
      int         i;
      logic [7:0] sr, sg, sb;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_format(FMT_RGB24);

      // destination grid of 8 x 8 x 4 levels, black first and white-ish last
      for (i = 0; i < PAL_DEPTH; i++)
         host_beats.push_back(table_item(MODE_DPAL, 15'($urandom), 8'(i), 8'(36 * (i >> 5)),
                                         8'(36 * ((i >> 2) & 7)), 8'(85 * (i & 3)),
                                         8'($urandom)));
      for (i = 0; i < PAL_DEPTH; i++) begin
         sr = (i == 0) ? 8'h00 : (i == PAL_DEPTH - 1) ? 8'hFF : 8'($urandom);
         sg = (i == 0) ? 8'h00 : (i == PAL_DEPTH - 1) ? 8'hFF : 8'($urandom);
         sb = (i == 0) ? 8'h00 : (i == PAL_DEPTH - 1) ? 8'hFF : 8'($urandom);
         host_beats.push_back(table_item(MODE_SPAL, 15'($urandom), 8'(i), sr, sg, sb,
                                         8'($urandom)));
      end
      // map each key to its grid cell, with a scatter of arbitrary entries
      for (i = 0; i < MAP_DEPTH; i++)
         host_beats.push_back(table_item(MODE_MAP, 15'(i),
                                         ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                     : {i[14:12], i[9:7], i[4:3]},
                                         8'($urandom), 8'($urandom), 8'($urandom),
                                         8'($urandom)));

      // two lines of equal length, so the above-right neighbour of the end
      // pixel is the cleared entry; table writes of every kind mid-line
      host_beats.push_back(pixel_item(24'h000000, 1'b0));
      host_beats.push_back(pixel_item(24'hFFFFFF, 1'b0));
      host_beats.push_back(pixel_item(24'hFF00FF, 1'b0));
      host_beats.push_back(pixel_item(24'h00FF00, 1'b1));
      host_beats.push_back(pixel_item(24'h808080, 1'b0));
      host_beats.push_back(table_item(MODE_MAP, 15'h0000, 8'h00, 8'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom)));
      host_beats.push_back(table_item(MODE_MAP, 15'h7FFF, 8'hFF, 8'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom)));
      host_beats.push_back(pixel_item(24'h7F7F7F, 1'b0));
      host_beats.push_back(table_item(MODE_DPAL, 15'($urandom), 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                      8'hFF));
      host_beats.push_back(table_item(MODE_SPAL, 15'($urandom), 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'($urandom)));
      host_beats.push_back(pixel_item(24'h123456, 1'b0));
      host_beats.push_back(pixel_item(24'hEDCBA9, 1'b1));
      host_beats.push_back(pixel_item(24'hFFFFFF, 1'b1));

      // packed format: upper byte and bit 5 must have no effect
      set_format(FMT_RGB16);
      host_beats.push_back(pixel_item(24'h00FFFF, 1'b0));
      host_beats.push_back(pixel_item(24'hFF0000, 1'b0));
      host_beats.push_back(pixel_item(24'h000020, 1'b0));
      host_beats.push_back(pixel_item(24'hFFFFDF, 1'b1));

      set_format(FMT_INDEXED);
      host_beats.push_back(pixel_item(24'h000000, 1'b0));
      host_beats.push_back(pixel_item(24'hFFFFFF, 1'b0));
      host_beats.push_back(pixel_item(24'hAB5C37, 1'b1));

      // spare format code behaves as 24-bit
      set_format(FMT_UNUSED);
      host_beats.push_back(pixel_item(24'hFFFFFF, 1'b0));
      host_beats.push_back(pixel_item(24'h000000, 1'b1));

      // one line past the buffer width: the column holds at the end
      set_format(FMT_RGB24);
      for (i = 0; i < MAX_WIDTH + 6; i++)
         host_beats.push_back(pixel_item(24'($urandom), i == MAX_WIDTH + 5));
      for (i = 0; i < 3; i++)
         host_beats.push_back(pixel_item(24'($urandom), i == 2));

      set_format(FMT_RGB16);
      random_lines(100);
      set_format(FMT_INDEXED);
      random_lines(100);
      set_format(FMT_UNUSED);
      random_lines(100);
      set_format(FMT_RGB24);
      random_lines(100);

      wait_idle();
      repeat (12) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/edd_pkg.sv
rtl/edd_ram.sv
rtl/error_diffusion_dither.sv
rtl/edd_checker.sv
dv/error_diffusion_dither_test.sv
